@@ rtl/lpfc_pkg.sv @@
`default_nettype none
package lpfc_pkg;

  localparam int BYTE_W   = 8;
  localparam int POS_W    = 9;
  localparam int ADDR_W   = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [POS_W-1:0] POS_ADDR          = 9'd0;
  localparam logic [POS_W-1:0] POS_CMD           = 9'd1;
  localparam logic [POS_W-1:0] POS_LEN           = 9'd2;
  localparam logic [POS_W-1:0] POS_HEADER_CHECK  = 9'd3;
  localparam logic [POS_W-1:0] POS_FIRST_PAYLOAD = 9'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS  = 2'd1;

  localparam logic [ADDR_W-1:0] OWN_ADDRESS_RESET = 4'h3;

  typedef enum logic [2:0] {
    K_ADDR,
    K_CMD,
    K_LEN,
    K_HCHK,
    K_PAYLOAD,
    K_PCHK
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED      = 2'd0,
    ST_HEADER_BAD    = 2'd1,
    ST_PAYLOAD_BAD   = 2'd2,
    ST_OTHER_ADDRESS = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    kind_t             kind;
    logic              last;
  } qentry_t;

  typedef struct packed {
    logic              full;
    logic              valid;
    logic [Q_CNT_W-1:0] count;
  } qstat_t;

endpackage
`default_nettype wire

@@ rtl/lpfc_front.sv @@
`default_nettype none
module lpfc_front
  import lpfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output qentry_t                entry
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [POS_W-1:0]  last_pos;

  assign last_pos = POS_FIRST_PAYLOAD + {1'b0, len_r};

  always_comb begin
    entry.data = rx_byte;
    entry.pos  = pos_r;
    entry.last = 1'b0;
    if (pos_r == POS_ADDR) begin
      entry.kind = K_ADDR;
    end else if (pos_r == POS_CMD) begin
      entry.kind = K_CMD;
    end else if (pos_r == POS_LEN) begin
      entry.kind = K_LEN;
    end else if (pos_r == POS_HEADER_CHECK) begin
      entry.kind = K_HCHK;
      entry.last = (len_r == '0);
    end else if (pos_r < last_pos) begin
      entry.kind = K_PAYLOAD;
    end else begin
      entry.kind = K_PCHK;
      entry.last = 1'b1;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    len_nxt = len_r;
    if (push) begin
      pos_nxt = entry.last ? POS_ADDR : pos_r + 1'b1;
      if (entry.kind == K_LEN) begin
        len_nxt = rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_ADDR;
      len_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/lpfc_queue.sv @@
`default_nettype none
module lpfc_queue
  import lpfc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire qentry_t wr_entry,
  input  wire logic    pop,
  output qentry_t      rd_entry,
  output qstat_t       stat
);

  qentry_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  assign rd_entry   = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign stat.valid = (count_r != '0);
  assign stat.count = count_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/lpfc_back.sv @@
`default_nettype none
module lpfc_back
  import lpfc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [BYTE_W-1:0]   check_offset,
  input  wire logic [ADDR_W-1:0]   own_address,
  input  wire qentry_t             entry,
  input  wire logic                entry_valid,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [BYTE_W-1:0]        out_byte,
  output logic [POS_W-1:0]         out_pos,
  output logic                     out_is_payload,
  output logic                     out_frame_end,
  output logic [STATUS_W-1:0]      out_status
);

  logic [ADDR_W-1:0]   dest_r, dest_nxt;
  logic [BYTE_W-1:0]   sum_r, sum_nxt;
  logic                hok_r, hok_nxt;
  logic                valid_r, valid_nxt;
  logic [BYTE_W-1:0]   byte_r;
  logic [POS_W-1:0]    pos_r;
  logic                payload_r, end_r;
  logic [STATUS_W-1:0] status_r;
  logic                payload_good;
  status_t             verdict;
  status_t             status_nxt;

  assign pop = entry_valid && (!valid_r || !out_stall);

  always_comb begin
    dest_nxt     = dest_r;
    sum_nxt      = sum_r;
    hok_nxt      = hok_r;
    payload_good = 1'b1;
    case (entry.kind)
      K_ADDR: begin
        dest_nxt = entry.data[ADDR_W-1:0];
        sum_nxt  = check_offset + entry.data;
      end
      K_CMD, K_LEN, K_PAYLOAD: begin
        sum_nxt = sum_r + entry.data;
      end
      K_HCHK: begin
        hok_nxt = (entry.data == sum_r);
      end
      K_PCHK: begin
        payload_good = (entry.data == sum_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (dest_r != own_address) begin
      verdict = ST_OTHER_ADDRESS;
    end else if (!hok_nxt) begin
      verdict = ST_HEADER_BAD;
    end else if (!payload_good) begin
      verdict = ST_PAYLOAD_BAD;
    end else begin
      verdict = ST_ACCEPTED;
    end
    status_nxt = entry.last ? verdict : ST_ACCEPTED;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dest_r  <= '0;
      sum_r   <= '0;
      hok_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (pop) begin
        dest_r <= dest_nxt;
        sum_r  <= sum_nxt;
        hok_r  <= hok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r    <= entry.data;
      pos_r     <= entry.pos;
      payload_r <= (entry.kind == K_PAYLOAD);
      end_r     <= entry.last;
      status_r  <= status_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_pos        = pos_r;
  assign out_is_payload = payload_r;
  assign out_frame_end  = end_r;
  assign out_status     = status_r;

endmodule
`default_nettype wire

@@ rtl/length_prefixed_frame_checker.sv @@
`default_nettype none
// Length-prefixed frame checker: takes one received byte per cycle while
// in_stall is low and echoes it with its frame position, a payload flag
// and, on the last byte of a frame, the verdict (accepted, header check bad,
// payload check bad, other address). Sustained rate is one item per clock
// while neither side stalls; each item enters the two-entry queue between
// the classifier and the checksum stage at the accepting edge and moves from
// there into the output register when that register is empty or not stalled.
// in_stall rises only when the queue is full, i.e. after the output has
// been stalled. Configuration: index 0 check_offset, index 1 own_address
// (reset 3); cfg_ready is always high and other indexes are ignored.
module length_prefixed_frame_checker
  import lpfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [BYTE_W-1:0]         out_out_byte,
  output logic [POS_W-1:0]          out_frame_position,
  output logic                      out_is_payload,
  output logic                      out_frame_end,
  output logic [STATUS_W-1:0]       out_frame_status,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  logic [BYTE_W-1:0] check_offset_r;
  logic [ADDR_W-1:0] own_address_r;
  logic              push;
  logic              pop;
  qentry_t           front_entry;
  qentry_t           head_entry;
  qstat_t            qstat;

  assign cfg_ready = 1'b1;
  assign in_stall  = qstat.full;
  assign push      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_offset_r <= '0;
      own_address_r  <= OWN_ADDRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CHECK_OFFSET) begin
        check_offset_r <= cfg_data;
      end else if (cfg_index == CFG_OWN_ADDRESS) begin
        own_address_r <= cfg_data[ADDR_W-1:0];
      end
    end
  end

  lpfc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .rx_byte (in_rx_byte),
    .entry   (front_entry)
  );

  lpfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (front_entry),
    .pop      (pop),
    .rd_entry (head_entry),
    .stat     (qstat)
  );

  lpfc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .check_offset   (check_offset_r),
    .own_address    (own_address_r),
    .entry          (head_entry),
    .entry_valid    (qstat.valid),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_out_byte),
    .out_pos        (out_frame_position),
    .out_is_payload (out_is_payload),
    .out_frame_end  (out_frame_end),
    .out_status     (out_frame_status)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |-> out_frame_status == ST_ACCEPTED)
    else $error("status set on a byte that does not end a frame");

  a_payload_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_payload && out_frame_end))
    else $error("payload byte flagged as frame end");

  a_full_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(qstat.full) |-> $past(out_valid && out_stall))
    else $error("queue filled without output stall");

endmodule
`default_nettype wire

@@ dv/length_prefixed_frame_checker_tb.sv @@
`timescale 1ns / 1ps

module length_prefixed_frame_checker_tb;
  import lpfc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              payload;
    logic              last;
    status_t           status;
  } echo_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_out_byte;
  logic [POS_W-1:0]     out_frame_position;
  logic                 out_is_payload;
  logic                 out_frame_end;
  logic [STATUS_W-1:0]  out_frame_status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  length_prefixed_frame_checker DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_out_byte       (out_out_byte),
    .out_frame_position (out_frame_position),
    .out_is_payload     (out_is_payload),
    .out_frame_end      (out_frame_end),
    .out_frame_status   (out_frame_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // frame tracker and register copies
  logic [BYTE_W-1:0] offset_reg = 8'd0;
  logic [ADDR_W-1:0] own_addr_reg = OWN_ADDRESS_RESET;
  logic [POS_W-1:0]  cur_pos = '0;
  logic [ADDR_W-1:0] cur_dest = '0;
  logic [BYTE_W-1:0] cur_len = '0;
  logic [BYTE_W-1:0] cur_sum = '0;
  logic              cur_hok = 1'b0;

  echo_t             echo_due[$];
  logic [BYTE_W-1:0] frame_bytes[$];
  int                mismatch_count = 0;
  int                items_sent = 0;
  int                in_gap_pct = 20;
  int                out_gap_pct = 20;
  int                hold_req = 0;

  function automatic status_t frame_verdict(input logic payload_good);
    if (cur_dest != own_addr_reg) return ST_OTHER_ADDRESS;
    if (!cur_hok) return ST_HEADER_BAD;
    if (!payload_good) return ST_PAYLOAD_BAD;
    return ST_ACCEPTED;
  endfunction

  function automatic echo_t classify_byte(input logic [BYTE_W-1:0] b);
    echo_t            e;
    logic [POS_W-1:0] last_pos;
    last_pos  = POS_FIRST_PAYLOAD + {1'b0, cur_len};
    e.data    = b;
    e.pos     = cur_pos;
    e.payload = 1'b0;
    e.last    = 1'b0;
    e.status  = ST_ACCEPTED;
    if (cur_pos == POS_ADDR) begin
      cur_dest = b[ADDR_W-1:0];
      cur_sum  = offset_reg + b;
    end else if (cur_pos == POS_CMD) begin
      cur_sum = cur_sum + b;
    end else if (cur_pos == POS_LEN) begin
      cur_len = b;
      cur_sum = cur_sum + b;
    end else if (cur_pos == POS_HEADER_CHECK) begin
      cur_hok = (b == cur_sum);
      if (cur_len == 0) begin
        e.last   = 1'b1;
        e.status = frame_verdict(1'b1);
      end
    end else if (cur_pos < last_pos) begin
      e.payload = 1'b1;
      cur_sum   = cur_sum + b;
    end else begin
      e.last   = 1'b1;
      e.status = frame_verdict(b == cur_sum);
    end
    cur_pos = e.last ? '0 : cur_pos + 1'b1;
    return e;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // output side stall: random bursts, or a long hold on request
  initial begin : drive_out_stall
    int n;
    forever begin
      if (hold_req != 0) begin
        n = hold_req;
        hold_req = 0;
        out_stall <= 1'b1;
      end else if ($urandom_range(1, 100) <= out_gap_pct) begin
        n = $urandom_range(1, 5);
        out_stall <= 1'b1;
      end else begin
        n = 1;
        out_stall <= 1'b0;
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_echo
    echo_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (echo_due.size() == 0) begin
        note_mismatch($sformatf("unexpected item: byte %h pos %0d", out_out_byte,
                                out_frame_position));
      end else begin
        want = echo_due.pop_front();
        if (out_out_byte !== want.data || out_frame_position !== want.pos ||
            out_is_payload !== want.payload || out_frame_end !== want.last ||
            out_frame_status !== want.status) begin
          note_mismatch($sformatf(
            "mismatch: exp byte %h pos %0d pay %b end %b st %0d, got %h %0d %b %b %0d",
            want.data, want.pos, want.payload, want.last, want.status, out_out_byte,
            out_frame_position, out_is_payload, out_frame_end, out_frame_status));
        end
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    echo_due.push_back(classify_byte(b));
    items_sent++;
    if ($urandom_range(1, 100) <= in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    while (echo_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_CHECK_OFFSET) offset_reg = val;
    else if (idx == CFG_OWN_ADDRESS) own_addr_reg = val[ADDR_W-1:0];
    @(posedge clk);
  endtask

  // check bytes use the offset in force when the frame is built
  function automatic void build_frame(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] cmd,
                                      input logic [BYTE_W-1:0] len, input logic hdr_err,
                                      input logic pay_err);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    frame_bytes.delete();
    sum = offset_reg + addr + cmd + len;
    frame_bytes.push_back(addr);
    frame_bytes.push_back(cmd);
    frame_bytes.push_back(len);
    frame_bytes.push_back(hdr_err ? sum ^ 8'($urandom_range(1, 255)) : sum);
    if (len != 0) begin
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom);
        sum = sum + b;
        frame_bytes.push_back(b);
      end
      frame_bytes.push_back(pay_err ? sum ^ 8'($urandom_range(1, 255)) : sum);
    end
  endfunction

  task automatic send_slice(input int first, input int upto);
    for (int i = first; i < upto; i++) send_byte(frame_bytes[i]);
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] cmd,
                            input logic [BYTE_W-1:0] len, input logic hdr_err,
                            input logic pay_err);
    build_frame(addr, cmd, len, hdr_err, pay_err);
    send_slice(0, frame_bytes.size());
  endtask

  task automatic send_random_frame();
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] len;
    int                pick;
    pick = $urandom_range(0, 99);
    addr = 8'($urandom);
    if (pick < 65) addr[ADDR_W-1:0] = own_addr_reg;
    len = (pick % 50 == 7) ? 8'($urandom_range(13, 40)) : 8'($urandom_range(0, 12));
    send_frame(addr, 8'($urandom), len, $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 15);
  endtask

  // reset register values; high nibble ignored; verdict priorities
  task automatic test_reset_defaults();
    send_frame(8'hF3, 8'h00, 8'd0, 1'b0, 1'b0);
    send_frame(8'h34, 8'h81, 8'd1, 1'b1, 1'b0);
    send_frame(8'h03, 8'h7E, 8'd1, 1'b1, 1'b1);
    wait_idle();
  endtask

  // extreme register values, wrapping sums, ignored indexes
  task automatic test_config_extremes();
    write_reg(CFG_CHECK_OFFSET, 8'hFF);
    write_reg(CFG_OWN_ADDRESS, 8'h00);
    write_reg(CFG_SPARE_A, 8'h5C);
    write_reg(CFG_SPARE_B, 8'hA7);
    send_frame(8'hF0, 8'hFF, 8'd1, 1'b0, 1'b1);
    wait_idle();
    write_reg(CFG_CHECK_OFFSET, 8'h00);
    write_reg(CFG_OWN_ADDRESS, 8'h0F);
    send_frame(8'h0F, 8'h00, 8'd0, 1'b0, 1'b0);
    wait_idle();
  endtask

  // offset is latched at the address byte, address compared at the last byte
  task automatic test_midframe_config();
    write_reg(CFG_CHECK_OFFSET, 8'h10);
    write_reg(CFG_OWN_ADDRESS, 8'h05);
    build_frame(8'h05, 8'h22, 8'd1, 1'b0, 1'b0);
    send_slice(0, 2);
    wait_idle();
    write_reg(CFG_CHECK_OFFSET, 8'h80);
    send_slice(2, frame_bytes.size());
    build_frame(8'h06, 8'h33, 8'd0, 1'b0, 1'b0);
    send_slice(0, 3);
    wait_idle();
    write_reg(CFG_OWN_ADDRESS, 8'h06);
    send_slice(3, frame_bytes.size());
    wait_idle();
  endtask

  task automatic test_max_length();
    send_frame({4'hA, own_addr_reg}, 8'hC3, 8'd255, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_input_backpressure();
    in_gap_pct  = 0;
    out_gap_pct = 0;
    hold_req    = 40;
    repeat (3) send_frame({4'h9, own_addr_reg}, 8'h5A, 8'd6, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_frames();
    int start;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_CHECK_OFFSET, 8'($urandom));
      write_reg(CFG_OWN_ADDRESS, 8'($urandom));
      in_gap_pct  = (ph == 1) ? 0 : 10 * $urandom_range(1, 4);
      out_gap_pct = (ph == 2) ? 0 : 10 * $urandom_range(1, 4);
      start = items_sent;
      while (items_sent - start < 45) send_random_frame();
      wait_idle();
    end
  endtask

  task automatic test_quiet_tail();
    int start;
    in_gap_pct  = 0;
    out_gap_pct = 0;
    start = items_sent;
    while (items_sent - start < 40) send_random_frame();
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_midframe_config();
    test_max_length();
    test_input_backpressure();
    test_random_frames();
    test_quiet_tail();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && echo_due.size() == 0) begin
      $display("length_prefixed_frame_checker_tb passed");
    end else begin
      $display("length_prefixed_frame_checker_tb failed");
    end
    $finish;
  end

  initial begin
    #300000;
    $display("length_prefixed_frame_checker_tb failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lpfc_pkg.sv
rtl/lpfc_front.sv
rtl/lpfc_queue.sv
rtl/lpfc_back.sv
rtl/length_prefixed_frame_checker.sv
dv/length_prefixed_frame_checker_tb.sv
